// ===== design/rgad_pkg.sv =====
// ----------------------------------------------------------------------------
// rgad_pkg
// Shared types and constants for the RLE glyph alpha span decoder.
// ----------------------------------------------------------------------------
package rgad_pkg;

  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned COORD_W = 16;
  // Glyph column: below glyph_width (max 255) plus one run of up to 128
  localparam int unsigned COL_W   = 9;
  // Screen column arithmetic: 16-bit signed base plus glyph column
  localparam int unsigned SCOL_W  = 18;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned SPAN_W  = 2 * COORD_W + 2 * ALPHA_W;

  // Header byte fields
  localparam int unsigned HDR_REPEAT_BIT = 7;
  localparam logic [6:0]  HDR_COUNT_MASK = 7'h7f;

  // Register reset values
  localparam logic [ALPHA_W-1:0]        GLOBAL_ALPHA_RST  = 8'd255;
  localparam logic [ALPHA_W-1:0]        GLYPH_WIDTH_RST   = 8'd8;
  localparam logic [ALPHA_W-1:0]        SKIP_ROWS_RST     = 8'd0;
  localparam logic signed [COORD_W-1:0] ROW_START_COL_RST = 16'sd0;
  localparam logic signed [COORD_W-1:0] CLIP_LEFT_RST     = 16'sd0;
  localparam logic signed [COORD_W-1:0] CLIP_RIGHT_RST    = 16'sd32767;
  localparam logic signed [COORD_W-1:0] FIRST_ROW_RST     = 16'sd0;
  localparam logic signed [COORD_W-1:0] LAST_ROW_RST      = 16'sd0;

  typedef enum logic [IDX_W-1:0] {
    CFG_GLOBAL_ALPHA  = 3'd0,
    CFG_GLYPH_WIDTH   = 3'd1,
    CFG_SKIP_ROWS     = 3'd2,
    CFG_ROW_START_COL = 3'd3,
    CFG_CLIP_LEFT     = 3'd4,
    CFG_CLIP_RIGHT    = 3'd5,
    CFG_FIRST_ROW     = 3'd6,
    CFG_LAST_ROW      = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_e;

  typedef struct packed {
    logic [ALPHA_W-1:0]        global_alpha;
    logic [ALPHA_W-1:0]        glyph_width;
    logic [ALPHA_W-1:0]        skip_rows;
    logic signed [COORD_W-1:0] row_start_col;
    logic signed [COORD_W-1:0] clip_left;
    logic signed [COORD_W-1:0] clip_right;
    logic signed [COORD_W-1:0] first_row;
    logic signed [COORD_W-1:0] last_row;
  } cfg_t;

  // Packed in tdata order: lowest field last
  typedef struct packed {
    logic [ALPHA_W-1:0] blend_alpha;
    logic [ALPHA_W-1:0] span_length;
    logic [COORD_W-1:0] span_col;
    logic [COORD_W-1:0] span_row;
  } span_t;

endpackage

// ===== design/rgad_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rgad_cfg_regs
// Configuration register file, written through the indexed write channel.
// ----------------------------------------------------------------------------
module rgad_cfg_regs import rgad_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [IDX_W-1:0]     cfg_index_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GLOBAL_ALPHA:  cfg_d.global_alpha  = cfg_data_i[ALPHA_W-1:0];
        CFG_GLYPH_WIDTH:   cfg_d.glyph_width   = cfg_data_i[ALPHA_W-1:0];
        CFG_SKIP_ROWS:     cfg_d.skip_rows     = cfg_data_i[ALPHA_W-1:0];
        CFG_ROW_START_COL: cfg_d.row_start_col = cfg_data_i;
        CFG_CLIP_LEFT:     cfg_d.clip_left     = cfg_data_i;
        CFG_CLIP_RIGHT:    cfg_d.clip_right    = cfg_data_i;
        CFG_FIRST_ROW:     cfg_d.first_row     = cfg_data_i;
        CFG_LAST_ROW:      cfg_d.last_row      = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.global_alpha  <= GLOBAL_ALPHA_RST;
      cfg_q.glyph_width   <= GLYPH_WIDTH_RST;
      cfg_q.skip_rows     <= SKIP_ROWS_RST;
      cfg_q.row_start_col <= ROW_START_COL_RST;
      cfg_q.clip_left     <= CLIP_LEFT_RST;
      cfg_q.clip_right    <= CLIP_RIGHT_RST;
      cfg_q.first_row     <= FIRST_ROW_RST;
      cfg_q.last_row      <= LAST_ROW_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== design/rgad_alpha_scale.sv =====
// ----------------------------------------------------------------------------
// rgad_alpha_scale
// floor(alpha * global alpha / 255) with a reciprocal add in place of a divider.
// ----------------------------------------------------------------------------
module rgad_alpha_scale import rgad_pkg::*; (
  input  logic [ALPHA_W-1:0] alpha_i,
  input  logic [ALPHA_W-1:0] brush_i,
  output logic [ALPHA_W-1:0] alpha_o
);

  logic [2*ALPHA_W-1:0] prod;
  logic [2*ALPHA_W:0]   sum;

  // x / 255 == (x + 1 + (x >> 8)) >> 8, exact for any product of two 8-bit values
  assign prod    = alpha_i * brush_i;
  assign sum     = {1'b0, prod} + (2*ALPHA_W+1)'(1)
                 + {{(ALPHA_W+1){1'b0}}, prod[2*ALPHA_W-1:ALPHA_W]};
  assign alpha_o = sum[2*ALPHA_W-1:ALPHA_W];

endmodule

// ===== design/rgad_decode.sv =====
// ----------------------------------------------------------------------------
// rgad_decode
// Run-length decode state, row tracking and span clipping for one byte.
// ----------------------------------------------------------------------------
module rgad_decode import rgad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,      // byte leaves the input register
  input  logic [ALPHA_W-1:0] byte_i,
  input  logic               begin_i,
  input  cfg_t               cfg_i,
  output logic               span_vld_o,
  output span_t              span_o
);

  phase_e                    phase_q, phase_d;
  logic [ALPHA_W-1:0]        lit_q, lit_d;
  logic [ALPHA_W-1:0]        rep_q, rep_d;
  logic [COL_W-1:0]          col_q, col_d;
  logic [ALPHA_W-1:0]        rskip_q, rskip_d;
  logic signed [COORD_W-1:0] row_q, row_d;
  logic                      done_q, done_d;

  // state as seen after an optional glyph restart
  phase_e                    e_phase;
  logic [ALPHA_W-1:0]        e_lit, e_rep, e_rskip;
  logic [COL_W-1:0]          e_col;
  logic signed [COORD_W-1:0] e_row;
  logic                      e_done;

  logic [ALPHA_W-1:0]        scaled;
  logic [ALPHA_W-1:0]        cnt;
  logic                      pix_phase;
  logic signed [SCOL_W-1:0]  c0, c1, lo, hi, c0c, c1c, len;
  logic [COL_W-1:0]          col_end;
  logic [ALPHA_W-1:0]        lit_dec;
  logic                      run_end;

  always_comb begin
    if (begin_i) begin
      e_phase = PH_HEADER;
      e_lit   = '0;
      e_rep   = '0;
      e_col   = '0;
      e_rskip = '0;
      e_row   = cfg_i.first_row;
      e_done  = (cfg_i.skip_rows == '0) && (cfg_i.first_row > cfg_i.last_row);
    end else begin
      e_phase = phase_q;
      e_lit   = lit_q;
      e_rep   = rep_q;
      e_col   = col_q;
      e_rskip = rskip_q;
      e_row   = row_q;
      e_done  = done_q;
    end
  end

  rgad_alpha_scale u_scale (
    .alpha_i (byte_i),
    .brush_i (cfg_i.global_alpha),
    .alpha_o (scaled)
  );

  // span geometry and clipping
  always_comb begin
    pix_phase = (e_phase == PH_REPEAT) || (e_phase == PH_LITERAL);
    cnt       = (e_phase == PH_REPEAT) ? e_rep : ALPHA_W'(1);
    c0  = SCOL_W'(cfg_i.row_start_col) + $signed({{(SCOL_W-COL_W){1'b0}}, e_col});
    c1  = c0 + $signed({{(SCOL_W-ALPHA_W){1'b0}}, cnt}) - SCOL_W'(1);
    lo  = SCOL_W'(cfg_i.clip_left);
    hi  = SCOL_W'(cfg_i.clip_right);
    c0c = (c0 < lo) ? lo : c0;
    c1c = (c1 > hi) ? hi : c1;
    len = c1c - c0c + SCOL_W'(1);

    span_vld_o = adv_i && !e_done && pix_phase && (e_rskip >= cfg_i.skip_rows)
               && (scaled != '0) && (c0c <= c1c);
    span_o.span_row    = e_row;
    span_o.span_col    = c0c[COORD_W-1:0];
    span_o.span_length = len[ALPHA_W-1:0];
    span_o.blend_alpha = scaled;
  end

  // next state
  always_comb begin
    phase_d = e_phase;
    lit_d   = e_lit;
    rep_d   = e_rep;
    col_d   = e_col;
    rskip_d = e_rskip;
    row_d   = e_row;
    done_d  = e_done;
    lit_dec = e_lit - ALPHA_W'(1);
    col_end = e_col + ((e_phase == PH_REPEAT) ? COL_W'(e_rep) : COL_W'(1));
    run_end = 1'b0;

    if (!e_done) begin
      unique case (e_phase)
        PH_REPEAT: begin
          rep_d   = '0;
          run_end = 1'b1;
        end
        PH_LITERAL: begin
          lit_d   = lit_dec;
          col_d   = col_end;
          run_end = (lit_dec == '0);
        end
        default: begin
          if (byte_i[HDR_REPEAT_BIT]) begin
            rep_d   = {1'b0, byte_i[6:0] & HDR_COUNT_MASK} + ALPHA_W'(1);
            phase_d = PH_REPEAT;
          end else begin
            lit_d   = byte_i + ALPHA_W'(1);
            phase_d = PH_LITERAL;
          end
        end
      endcase
    end

    if (run_end) begin
      phase_d = PH_HEADER;
      col_d   = col_end;
      if (col_end >= COL_W'(cfg_i.glyph_width)) begin
        col_d = '0;
        if (e_rskip < cfg_i.skip_rows) begin
          rskip_d = e_rskip + ALPHA_W'(1);
          if ((rskip_d >= cfg_i.skip_rows) && (e_row > cfg_i.last_row)) begin
            done_d = 1'b1;
          end
        end else if (e_row >= cfg_i.last_row) begin
          done_d = 1'b1;
        end else begin
          row_d = e_row + COORD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      lit_q   <= '0;
      rep_q   <= '0;
      col_q   <= '0;
      rskip_q <= '0;
      row_q   <= '0;
      done_q  <= 1'b1;
    end else if (adv_i) begin
      phase_q <= phase_d;
      lit_q   <= lit_d;
      rep_q   <= rep_d;
      col_q   <= col_d;
      rskip_q <= rskip_d;
      row_q   <= row_d;
      done_q  <= done_d;
    end
  end

endmodule

// ===== design/rle_glyph_alpha_span_decoder.sv =====
// ----------------------------------------------------------------------------
// rle_glyph_alpha_span_decoder
// Decodes run-length compressed 8-bit alpha glyphs into clipped pixel spans.
// ----------------------------------------------------------------------------
// Takes one compressed glyph byte per clock on the slave stream (tuser marks
// the first header byte of a glyph) and produces at most one span per byte on
// the master stream. Throughput is one byte per cycle while the output does
// not stall; each byte is captured in the input register, then the single
// decode stage updates run/row state and writes its span, if any, into the
// output register, from which it leaves while m_axis_tready is high. A stalled
// output holds the byte in the input register and takes s_axis_tready low.
// Header bytes, skipped rows, fully clipped runs and zero alphas produce no
// span. A repeat run yields one span; each literal pixel yields a span of
// length one. Registers are written through the cfg channel, which is always
// ready; write them only while no byte is in flight.
// ----------------------------------------------------------------------------
module rle_glyph_alpha_span_decoder import rgad_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [IDX_W-1:0]     cfg_index_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  // compressed byte stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tuser,   // [0] glyph_begin
  // span stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [SPAN_W-1:0]    m_axis_tdata    // [15:0] span_row, [31:16] span_col,
                                               // [39:32] span_length, [47:40] blend_alpha
);

  cfg_t               cfg;

  // input register
  logic               in_vld_q;
  logic [ALPHA_W-1:0] in_byte_q;
  logic               in_begin_q;

  // result register
  logic               out_vld_q, out_vld_d;
  span_t              out_span_q;

  logic               adv;
  logic               span_vld;
  span_t              span;

  rgad_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The byte in the input register moves on whenever the result register
  // is free or being drained this cycle.
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_begin_q <= s_axis_tuser;
    end
  end

  rgad_decode u_dec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .byte_i     (in_byte_q),
    .begin_i    (in_begin_q),
    .cfg_i      (cfg),
    .span_vld_o (span_vld),
    .span_o     (span)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = span_vld;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && span_vld) begin
      out_span_q <= span;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_span_q;

  // a shown span always has pixels and visible alpha
  a_span_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_span_q.span_length != '0) && (out_span_q.blend_alpha != '0))
    else $error("span with zero length or alpha");

  // a byte held in the input register is not dropped while the output stalls
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> in_vld_q && $stable(in_byte_q) && $stable(in_begin_q))
    else $error("pending byte lost under stall");

  // input back-pressure only when both registers are full and output stalls
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q && out_vld_q && !m_axis_tready)
    else $error("input stalled without cause");

endmodule
